// File: src/rps_pkg.sv
// ----------------------------------------------------------------------------
// rps_pkg
// Shared codes, defaults and saturation helper for the radial profile
// superposition block.
// ----------------------------------------------------------------------------
package rps_pkg;

    localparam int DEF_MAX_BALLS      = 16;
    localparam int DEF_PROFILE_POINTS = 256;
    localparam int DEF_GRID_SIZE      = 1024;

    localparam logic [1:0] OP_LOAD_BALL  = 2'd0;
    localparam logic [1:0] OP_LOAD_POINT = 2'd1;
    localparam logic [1:0] OP_EVAL       = 2'd2;

    localparam logic [1:0] CFG_ACTIVE    = 2'd0;
    localparam logic [1:0] CFG_GRID_MIN  = 2'd1;
    localparam logic [1:0] CFG_GRID_STEP = 2'd2;

    localparam logic signed [67:0] SAT_HI = 68'sh0_0000_0000_7FFF_FFFF;
    localparam logic signed [67:0] SAT_LO = -68'sh0_0000_0000_8000_0000;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
        logic signed [31:0] y;
        if (x > SAT_HI) begin
            y = 32'sh7FFF_FFFF;
        end else if (x < SAT_LO) begin
            y = 32'sh8000_0000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

endpackage

// File: src/radial_profile_superposition.sv
// ----------------------------------------------------------------------------
// radial_profile_superposition
// Sums interpolated radial profiles of up to MAX_BALLS balls at one voxel,
// with phase and rate terms, using one shared multiplier under a sequencer.
// ----------------------------------------------------------------------------
// channel  | direction | handshake          | payload
// command  | in        | start, busy        | i_op .. i_angular_freq
// result   | out       | o_valid (strobe)   | o_real_part .. o_imag_rate
// config   | in        | i_cfg_we           | i_cfg_index, i_cfg_data
//
// Loads (op 0, 1) and op 3 finish in the accept cycle; busy stays low.
// A voxel holds busy through the grid position set-up and, for each active ball, the
// 32-step square root, the search over profile memory (up to eight steps,
// registered reads) and, where needed, the 32-step divider.
// Reset is synchronous, active low; table contents are undefined until loaded.
// The result strobe lasts one cycle; the receiver cannot stall it.
module radial_profile_superposition
    import rps_pkg::*;
#(
    parameter int MAX_BALLS      = DEF_MAX_BALLS,
    parameter int PROFILE_POINTS = DEF_PROFILE_POINTS,
    parameter int GRID_SIZE      = DEF_GRID_SIZE
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic [1:0]         i_op,
    input  logic [3:0]         i_ball_index,
    input  logic [8:0]         i_entry_index,
    input  logic [9:0]         i_grid_x,
    input  logic [9:0]         i_grid_y,
    input  logic [9:0]         i_grid_z,
    input  logic signed [31:0] i_word_a,
    input  logic signed [31:0] i_word_b,
    input  logic signed [31:0] i_word_c,
    input  logic signed [17:0] i_phase_cos,
    input  logic signed [17:0] i_phase_sin,
    input  logic signed [31:0] i_angular_freq,
    output logic               o_valid,
    output logic signed [31:0] o_real_part,
    output logic signed [31:0] o_imag_part,
    output logic signed [31:0] o_real_rate,
    output logic signed [31:0] o_imag_rate
);

    localparam int BW = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1;
    localparam int KW = $clog2(MAX_BALLS + 1);
    localparam int PW = $clog2(PROFILE_POINTS);
    localparam int AW = $clog2(MAX_BALLS * PROFILE_POINTS);
    localparam int DEPTH = MAX_BALLS * PROFILE_POINTS;
    localparam logic [6:0]  MB    = 7'(MAX_BALLS);
    localparam logic [12:0] PPMAX = 13'(PROFILE_POINTS);
    localparam logic [12:0] GMAX  = 13'(GRID_SIZE - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_POS_MUL, S_POS_ADD, S_DIFF, S_SQ_MUL, S_SQ_ACC, S_SQRT,
        S_RD_FIRST, S_CHK_FIRST, S_CHK_LAST, S_SEARCH, S_SRCH_CHK, S_RD_HI,
        S_INTERP0, S_INTERP1, S_DIV_INIT, S_DIV, S_DIV_END, S_PMUL, S_PACC,
        S_DONE
    } t_state;

    t_state r_state;
    logic [1:0] r_cnt;
    logic [KW-1:0] r_k;
    logic r_valid;

    logic [4:0]         r_active;
    logic signed [31:0] r_grid_min;
    logic [30:0]        r_grid_step;

    logic signed [31:0] r_cx [MAX_BALLS];
    logic signed [31:0] r_cy [MAX_BALLS];
    logic signed [31:0] r_cz [MAX_BALLS];
    logic signed [17:0] r_cos [MAX_BALLS];
    logic signed [17:0] r_sin [MAX_BALLS];
    logic signed [31:0] r_freq [MAX_BALLS];
    logic [8:0]         r_npts [MAX_BALLS];

    logic signed [31:0] r_rad_mem [DEPTH];
    logic signed [31:0] r_val_mem [DEPTH];
    logic signed [31:0] r_rad_q;
    logic signed [31:0] r_val_q;

    logic [9:0]         r_idx [3];
    logic signed [44:0] r_pos [3];
    logic signed [31:0] r_d;
    logic [63:0]        r_sum;
    logic [63:0]        r_v;
    logic [63:0]        r_res;
    logic [63:0]        r_bit;
    logic [5:0]         r_it;
    logic [PW-1:0]      r_lo;
    logic [PW-1:0]      r_hi;
    logic signed [31:0] r_rlo;
    logic signed [31:0] r_rhi;
    logic signed [31:0] r_flo;
    logic signed [31:0] r_fhi;
    logic signed [33:0] r_a;
    logic signed [32:0] r_dd;
    logic signed [32:0] r_df;
    logic [31:0]        r_rem;
    logic [31:0]        r_qs;
    logic signed [31:0] r_f;
    logic signed [31:0] r_fc;
    logic signed [31:0] r_fs;
    logic signed [31:0] r_acc [4];
    logic signed [65:0] r_prod;

    logic signed [32:0] m_a;
    logic signed [32:0] m_b;
    logic [BW-1:0]      kb;
    logic [12:0]        idx13;
    logic [12:0]        n13;
    logic [12:0]        ncl;
    logic [PW-1:0]      last;
    logic [PW:0]        mid_sum;
    logic [PW-1:0]      mid;
    logic               gap;
    logic [AW-1:0]      base;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               mem_we;
    logic [KW-1:0]      nb;
    logic signed [32:0] r33;
    logic signed [32:0] rad33;
    logic [64:0]        root_try;
    logic [32:0]        div_t;
    logic signed [31:0] ctr_sel;
    logic signed [67:0] prod_sh;
    logic signed [31:0] term;
    logic signed [33:0] f_sum;
    logic               ball_ok;
    logic               entry_ok;

    always_comb begin
        kb      = r_k[BW-1:0];
        idx13   = (13'(r_idx[r_cnt]) > GMAX) ? GMAX : 13'(r_idx[r_cnt]);
        n13     = 13'(r_npts[kb]);
        if (n13 < 13'd2) begin
            ncl = 13'd2;
        end else if (n13 > PPMAX) begin
            ncl = PPMAX;
        end else begin
            ncl = n13;
        end
        last    = PW'(ncl - 13'd1);
        mid_sum = (PW + 1)'(r_lo) + (PW + 1)'(r_hi);
        mid     = mid_sum[PW:1];
        gap     = (PW + 1)'(r_hi) > ((PW + 1)'(r_lo) + (PW + 1)'(1));
        base    = AW'(kb) * AW'(PROFILE_POINTS);
        nb      = (7'(r_active) > MB) ? KW'(MAX_BALLS) : KW'(r_active);
        r33     = $signed({1'b0, r_res[31:0]});
        rad33   = 33'(r_rad_q);
        root_try = {1'b0, r_v} - ({1'b0, r_res} + {1'b0, r_bit});
        div_t   = {r_rem, r_qs[31]};
        f_sum   = (r_df < 0) ? (34'(r_flo) - 34'($signed({1'b0, r_qs})))
                             : (34'(r_flo) + 34'($signed({1'b0, r_qs})));
        ball_ok  = 7'(i_ball_index) < MB;
        entry_ok = 13'(i_entry_index) < PPMAX;
        wr_addr  = AW'(AW'(BW'(i_ball_index)) * AW'(PROFILE_POINTS)) + AW'(i_entry_index);
        mem_we   = (r_state == S_IDLE) && start && (i_op == OP_LOAD_POINT)
                   && ball_ok && entry_ok;

        unique case (r_cnt)
            2'd0:    ctr_sel = r_cx[kb];
            2'd1:    ctr_sel = r_cy[kb];
            default: ctr_sel = r_cz[kb];
        endcase

        unique case (r_state)
            S_CHK_FIRST: rd_addr = base + AW'(last);
            S_SEARCH:    rd_addr = base + AW'(gap ? mid : r_lo);
            S_RD_HI:     rd_addr = base + AW'(r_hi);
            default:     rd_addr = base;
        endcase

        m_a = '0;
        m_b = '0;
        unique case (r_state)
            S_POS_MUL: begin
                m_a = $signed({20'd0, idx13});
                m_b = $signed({2'd0, r_grid_step});
            end
            S_SQ_MUL: begin
                m_a = 33'(r_d);
                m_b = 33'(r_d);
            end
            S_INTERP1: begin
                m_a = r_a[32:0];
                m_b = (r_df < 0) ? -r_df : r_df;
            end
            S_PMUL: begin
                unique case (r_cnt)
                    2'd0: begin m_a = 33'(r_f); m_b = 33'(r_cos[kb]); end
                    2'd1: begin m_a = 33'(r_f); m_b = 33'(r_sin[kb]); end
                    2'd2: begin m_a = 33'(r_freq[kb]); m_b = 33'(r_fs); end
                    default: begin m_a = 33'(r_freq[kb]); m_b = 33'(r_fc); end
                endcase
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase

        prod_sh = (r_cnt == 2'd2) ? ((-68'(r_prod)) >>> 16) : (68'(r_prod) >>> 16);
        term    = sat32(prod_sh);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
        if (mem_we) begin
            r_rad_mem[wr_addr] <= i_word_a;
            r_val_mem[wr_addr] <= i_word_b;
        end
        r_rad_q <= r_rad_mem[rd_addr];
        r_val_q <= r_val_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= 1'b0;
            r_cnt       <= '0;
            r_k         <= '0;
            r_active    <= 5'd1;
            r_grid_min  <= '0;
            r_grid_step <= 31'd65536;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ACTIVE:    r_active    <= i_cfg_data[4:0];
                    CFG_GRID_MIN:  r_grid_min  <= i_cfg_data;
                    CFG_GRID_STEP: r_grid_step <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        if (i_op == OP_LOAD_BALL && ball_ok) begin
                            r_cx[BW'(i_ball_index)]   <= i_word_a;
                            r_cy[BW'(i_ball_index)]   <= i_word_b;
                            r_cz[BW'(i_ball_index)]   <= i_word_c;
                            r_cos[BW'(i_ball_index)]  <= i_phase_cos;
                            r_sin[BW'(i_ball_index)]  <= i_phase_sin;
                            r_freq[BW'(i_ball_index)] <= i_angular_freq;
                            r_npts[BW'(i_ball_index)] <= i_entry_index;
                        end else if (i_op == OP_EVAL) begin
                            r_idx[0] <= i_grid_x;
                            r_idx[1] <= i_grid_y;
                            r_idx[2] <= i_grid_z;
                            for (int j = 0; j < 4; j++) begin
                                r_acc[j] <= '0;
                            end
                            r_cnt   <= '0;
                            r_k     <= '0;
                            r_state <= S_POS_MUL;
                        end
                    end
                end
                S_POS_MUL: r_state <= S_POS_ADD;
                S_POS_ADD: begin
                    r_pos[r_cnt] <= 45'(r_grid_min) + $signed({2'd0, r_prod[42:0]});
                    if (r_cnt == 2'd2) begin
                        r_cnt <= '0;
                        r_sum <= '0;
                        r_state <= (nb == '0) ? S_DONE : S_DIFF;
                    end else begin
                        r_cnt   <= r_cnt + 2'd1;
                        r_state <= S_POS_MUL;
                    end
                end
                S_DIFF: begin
                    r_d     <= sat32(68'(r_pos[r_cnt]) - 68'(ctr_sel));
                    r_state <= S_SQ_MUL;
                end
                S_SQ_MUL: r_state <= S_SQ_ACC;
                S_SQ_ACC: begin
                    if (r_cnt == 2'd2) begin
                        r_v     <= r_sum + r_prod[63:0];
                        r_res   <= '0;
                        r_bit   <= 64'h4000_0000_0000_0000;
                        r_it    <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_sum   <= r_sum + r_prod[63:0];
                        r_cnt   <= r_cnt + 2'd1;
                        r_state <= S_DIFF;
                    end
                end
                S_SQRT: begin
                    if (!root_try[64]) begin
                        r_v   <= root_try[63:0];
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_it  <= r_it + 6'd1;
                    if (r_it == 6'd31) begin
                        r_state <= S_RD_FIRST;
                    end
                end
                S_RD_FIRST: r_state <= S_CHK_FIRST;
                S_CHK_FIRST: begin
                    if (r33 <= rad33) begin
                        r_f     <= r_val_q;
                        r_state <= S_PMUL;
                    end else begin
                        r_rlo   <= r_rad_q;
                        r_state <= S_CHK_LAST;
                    end
                end
                S_CHK_LAST: begin
                    if (r33 >= rad33) begin
                        r_f     <= '0;
                        r_state <= S_PMUL;
                    end else begin
                        r_rhi   <= r_rad_q;
                        r_lo    <= '0;
                        r_hi    <= last;
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: r_state <= gap ? S_SRCH_CHK : S_RD_HI;
                S_SRCH_CHK: begin
                    if (rad33 <= r33) begin
                        r_lo  <= mid;
                        r_rlo <= r_rad_q;
                    end else begin
                        r_hi  <= mid;
                        r_rhi <= r_rad_q;
                    end
                    r_state <= S_SEARCH;
                end
                S_RD_HI: begin
                    r_flo   <= r_val_q;
                    r_state <= S_INTERP0;
                end
                S_INTERP0: begin
                    r_fhi   <= r_val_q;
                    r_a     <= 34'(r33) - 34'(r_rlo);
                    r_dd    <= 33'(r_rhi) - 33'(r_rlo);
                    r_df    <= 33'(r_val_q) - 33'(r_flo);
                    r_state <= S_INTERP1;
                end
                S_INTERP1: begin
                    if (r_dd <= 0 || r_a <= 0) begin
                        r_f     <= r_flo;
                        r_state <= S_PMUL;
                    end else if (r_a >= 34'(r_dd)) begin
                        r_f     <= r_fhi;
                        r_state <= S_PMUL;
                    end else begin
                        r_state <= S_DIV_INIT;
                    end
                end
                S_DIV_INIT: begin
                    r_rem   <= r_prod[63:32];
                    r_qs    <= r_prod[31:0];
                    r_it    <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_t >= {1'b0, r_dd[31:0]}) begin
                        r_rem <= 32'(div_t - {1'b0, r_dd[31:0]});
                        r_qs  <= {r_qs[30:0], 1'b1};
                    end else begin
                        r_rem <= div_t[31:0];
                        r_qs  <= {r_qs[30:0], 1'b0};
                    end
                    r_it <= r_it + 6'd1;
                    if (r_it == 6'd31) begin
                        r_state <= S_DIV_END;
                    end
                end
                S_DIV_END: begin
                    r_f     <= f_sum[31:0];
                    r_state <= S_PMUL;
                end
                S_PMUL: r_state <= S_PACC;
                S_PACC: begin
                    r_acc[r_cnt] <= sat32(68'(r_acc[r_cnt]) + 68'(term));
                    if (r_cnt == 2'd0) begin
                        r_fc <= term;
                    end
                    if (r_cnt == 2'd1) begin
                        r_fs <= term;
                    end
                    if (r_cnt == 2'd3) begin
                        r_cnt <= '0;
                        r_sum <= '0;
                        r_k   <= r_k + KW'(1);
                        r_state <= (r_k + KW'(1) == nb) ? S_DONE : S_DIFF;
                    end else begin
                        r_cnt   <= r_cnt + 2'd1;
                        r_state <= S_PMUL;
                    end
                end
                S_DONE: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_real_part = r_acc[0];
    assign o_imag_part = r_acc[1];
    assign o_real_rate = r_acc[2];
    assign o_imag_rate = r_acc[3];

    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == OP_EVAL) |=> busy)
        else $error("evaluate did not start the sequencer");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy && $past(r_state == S_DONE))
        else $error("result strobe outside of finish");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

endmodule
